// ===== hw/rtl/resp_array_parser_macros.svh =====
// assertion macros shared by the parser rtl
`ifndef RESP_ARRAY_PARSER_MACROS_SVH
`define RESP_ARRAY_PARSER_MACROS_SVH

// same-cycle implication on the block clock, off during reset
`define RAP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the block clock, off during reset
`define RAP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/rap_pkg.sv =====
package rap_pkg;

  // default accumulator width for decimal lines
  localparam int RAP_VALUE_BITS = 32;

  // fixed result field widths
  localparam int VALUE_OUT_BITS  = 32;
  localparam int ITEM_INDEX_BITS = 31;

  localparam logic [ITEM_INDEX_BITS-1:0] COUNT_MAX = '1;

  // characters of the protocol
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  // result kinds
  typedef enum logic [1:0] {
    KIND_COUNT  = 2'd0,
    KIND_LENGTH = 2'd1,
    KIND_DATA   = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  // decimal line parse progress
  typedef enum logic [1:0] {
    DEC_START   = 2'd0,
    DEC_SIGN    = 2'd1,
    DEC_DIGITS  = 2'd2,
    DEC_STOPPED = 2'd3
  } dec_phase_t;

endpackage

// ===== hw/rtl/rap_in_if.sv =====
// byte stream channel
interface rap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, output in_byte, output end_of_buffer, input ready);
  modport sink (input valid, input in_byte, input end_of_buffer, output ready);
endinterface

// ===== hw/rtl/rap_out_if.sv =====
// parse result channel
interface rap_out_if;
  logic                                          valid;
  logic                                          ready;
  rap_pkg::kind_t                                kind;
  logic signed [rap_pkg::VALUE_OUT_BITS-1:0]     value;
  logic                                          length_mismatch;
  logic        [rap_pkg::ITEM_INDEX_BITS-1:0]    item_index;
  logic                                          all_items_done;

  modport source (output valid, output kind, output value, output length_mismatch,
                  output item_index, output all_items_done, input ready);
  modport sink (input valid, input kind, input value, input length_mismatch,
                input item_index, input all_items_done, output ready);
endinterface

// ===== hw/rtl/resp_array_parser.sv =====
// Streaming parser for an array of bulk strings ("*N", then "$len" and data lines,
// each ended by CR LF). One byte is taken per cycle with no gaps of its own while no
// result waits unread; each byte gives at most one result, which appears in the result
// register in the cycle after the byte is taken. The cycle is set by the decimal
// accumulator update (multiply by ten as shift-add, then a saturation compare) in a
// single pass. A byte is held back until the next one arrives to spot CR LF, so the
// last byte of each buffer is never parsed; after the byte marked end_of_buffer the
// whole parser state is cleared. Once the completed items reach the array count, bytes
// are ignored until the buffer ends. Decimal lines saturate to the signed VALUE_BITS
// range and the value field carries the low 32 bits of the sign-extended number.
`include "resp_array_parser_macros.svh"

module resp_array_parser #(
  parameter int VALUE_BITS = rap_pkg::RAP_VALUE_BITS
) (
  input  logic      clk,
  input  logic      rst,
  rap_in_if.sink    stream,
  rap_out_if.source result
);

  localparam int VB = VALUE_BITS;
  localparam int IB = rap_pkg::ITEM_INDEX_BITS;
  localparam int OB = rap_pkg::VALUE_OUT_BITS;
  // compare width wide enough for signed counts and 31-bit lengths
  localparam int CW = ((VB > IB) ? VB : IB) + 1;
  localparam int PW = VB + 4;

  // parser state
  logic                    count_known, count_known_next;
  logic                    length_known, length_known_next;
  logic signed [VB-1:0]    array_count, array_count_next;
  logic signed [VB-1:0]    declared_length, declared_length_next;
  logic [IB-1:0]           items_done, items_done_next;
  logic [IB-1:0]           line_length, line_length_next;
  logic [VB-1:0]           decimal_value, decimal_value_next;
  rap_pkg::dec_phase_t     decimal_phase, decimal_phase_next;
  logic                    decimal_negative, decimal_negative_next;
  logic                    held_valid, held_valid_next;
  logic [7:0]              held_byte, held_byte_next;
  logic                    finished, finished_next;
  logic                    at_line_start, at_line_start_next;

  // result register
  logic                    out_valid;
  rap_pkg::kind_t          out_kind;
  logic signed [OB-1:0]    out_value;
  logic                    out_mismatch;
  logic [IB-1:0]           out_index;
  logic                    out_done;

  // combinational result of this byte
  logic                    emit;
  rap_pkg::kind_t          emit_kind;
  logic signed [OB-1:0]    emit_value;
  logic                    emit_mismatch;
  logic                    emit_done;
  logic [IB-1:0]           emit_index;

  // decimal feed of the held byte
  logic                    is_digit;
  logic [3:0]              digit;
  logic [PW-1:0]           scaled;
  logic [PW-1:0]           limit;
  logic [VB-1:0]           feed_value;
  rap_pkg::dec_phase_t     feed_phase;
  logic                    feed_negative;
  logic signed [VB-1:0]    dec_result;
  logic signed [CW-1:0]    dec_ext;
  logic signed [CW-1:0]    count_ext;
  logic signed [CW-1:0]    length_ext;
  logic signed [CW-1:0]    line_ext;
  logic signed [CW-1:0]    items_ext;
  logic [IB-1:0]           items_inc;
  logic                    in_fire;
  logic                    is_line_end;

  assign stream.ready = !out_valid || result.ready;
  assign in_fire      = stream.valid && stream.ready;
  assign is_line_end  = (held_byte == rap_pkg::CHAR_CR) && (stream.in_byte == rap_pkg::CHAR_LF);

  // digit step: value*10 + d, saturating at the signed limit
  assign is_digit = (held_byte >= rap_pkg::CHAR_ZERO) && (held_byte <= rap_pkg::CHAR_NINE);
  assign digit    = held_byte[3:0];
  assign scaled   = ({4'b0, decimal_value} << 3) + ({4'b0, decimal_value} << 1)
                    + {{(PW-4){1'b0}}, digit};
  assign limit    = ({{(PW-1){1'b0}}, 1'b1} << (VB-1))
                    - {{(PW-1){1'b0}}, !decimal_negative};

  always_comb begin
    feed_value    = decimal_value;
    feed_phase    = decimal_phase;
    feed_negative = decimal_negative;
    if (decimal_phase != rap_pkg::DEC_STOPPED) begin
      if (is_digit) begin
        feed_phase = rap_pkg::DEC_DIGITS;
        feed_value = (scaled > limit) ? limit[VB-1:0] : scaled[VB-1:0];
      end else if ((decimal_phase == rap_pkg::DEC_START) &&
                   ((held_byte == rap_pkg::CHAR_MINUS) || (held_byte == rap_pkg::CHAR_PLUS))) begin
        feed_negative = (held_byte == rap_pkg::CHAR_MINUS);
        feed_phase    = rap_pkg::DEC_SIGN;
      end else begin
        feed_phase = rap_pkg::DEC_STOPPED;
      end
    end
  end

  // saturating count of completed items including the current line
  assign items_inc = (items_done != rap_pkg::COUNT_MAX) ? items_done + 1'b1 : items_done;

  // signed value of the finished decimal line and compare operands
  assign dec_result = decimal_negative ? -$signed(decimal_value) : $signed(decimal_value);
  assign dec_ext    = {{(CW-VB){dec_result[VB-1]}}, dec_result};
  assign count_ext  = {{(CW-VB){array_count[VB-1]}}, array_count};
  assign length_ext = {{(CW-VB){declared_length[VB-1]}}, declared_length};
  assign line_ext   = {{(CW-IB){1'b0}}, line_length};
  assign items_ext  = {{(CW-IB){1'b0}}, items_inc};

  // per-byte parser update
  always_comb begin
    count_known_next      = count_known;
    length_known_next     = length_known;
    array_count_next      = array_count;
    declared_length_next  = declared_length;
    items_done_next       = items_done;
    line_length_next      = line_length;
    decimal_value_next    = decimal_value;
    decimal_phase_next    = decimal_phase;
    decimal_negative_next = decimal_negative;
    held_valid_next       = held_valid;
    held_byte_next        = held_byte;
    finished_next         = finished;
    at_line_start_next    = at_line_start;
    emit                  = 1'b0;
    emit_kind             = rap_pkg::KIND_DATA;
    emit_value            = '0;
    emit_mismatch         = 1'b0;
    emit_done             = 1'b0;
    emit_index            = items_done;

    if (in_fire) begin
      if (!finished) begin
        if (!held_valid) begin
          held_byte_next  = stream.in_byte;
          held_valid_next = 1'b1;
        end else if (is_line_end) begin
          // line complete: report and clear line state
          held_valid_next       = 1'b0;
          emit                  = 1'b1;
          decimal_value_next    = '0;
          decimal_phase_next    = rap_pkg::DEC_START;
          decimal_negative_next = 1'b0;
          line_length_next      = '0;
          at_line_start_next    = 1'b1;
          if (!count_known) begin
            array_count_next = dec_result;
            count_known_next = 1'b1;
            emit_kind        = rap_pkg::KIND_COUNT;
            emit_value       = dec_ext[OB-1:0];
          end else if (!length_known) begin
            declared_length_next = dec_result;
            length_known_next    = 1'b1;
            emit_kind            = rap_pkg::KIND_LENGTH;
            emit_value           = dec_ext[OB-1:0];
          end else begin
            items_done_next = items_inc;
            emit_index      = items_inc;
            emit_kind       = rap_pkg::KIND_END;
            emit_value      = line_ext[OB-1:0];
            emit_mismatch   = (line_ext != length_ext);
            emit_done       = (items_ext == count_ext);
            if (emit_done) begin
              finished_next = 1'b1;
            end
          end
        end else begin
          // ordinary character
          held_byte_next     = stream.in_byte;
          at_line_start_next = 1'b0;
          if (!count_known) begin
            if (held_byte != rap_pkg::CHAR_STAR) begin
              decimal_value_next    = feed_value;
              decimal_phase_next    = feed_phase;
              decimal_negative_next = feed_negative;
            end
          end else if (at_line_start && (held_byte == rap_pkg::CHAR_DOLLAR)) begin
            length_known_next = 1'b0;
          end else if (!length_known) begin
            decimal_value_next    = feed_value;
            decimal_phase_next    = feed_phase;
            decimal_negative_next = feed_negative;
          end else begin
            if (line_length != rap_pkg::COUNT_MAX) begin
              line_length_next = line_length + 1'b1;
            end
            emit       = 1'b1;
            emit_kind  = rap_pkg::KIND_DATA;
            emit_value = {{(OB-8){1'b0}}, held_byte};
          end
        end
      end
      // end of buffer clears everything after this byte
      if (stream.end_of_buffer) begin
        count_known_next      = 1'b0;
        length_known_next     = 1'b0;
        array_count_next      = '0;
        declared_length_next  = '0;
        items_done_next       = '0;
        line_length_next      = '0;
        decimal_value_next    = '0;
        decimal_phase_next    = rap_pkg::DEC_START;
        decimal_negative_next = 1'b0;
        held_valid_next       = 1'b0;
        held_byte_next        = '0;
        finished_next         = 1'b0;
        at_line_start_next    = 1'b1;
      end
    end
  end

  // parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count_known      <= 1'b0;
      length_known     <= 1'b0;
      array_count      <= '0;
      declared_length  <= '0;
      items_done       <= '0;
      line_length      <= '0;
      decimal_value    <= '0;
      decimal_phase    <= rap_pkg::DEC_START;
      decimal_negative <= 1'b0;
      held_valid       <= 1'b0;
      held_byte        <= '0;
      finished         <= 1'b0;
      at_line_start    <= 1'b1;
    end else begin
      count_known      <= count_known_next;
      length_known     <= length_known_next;
      array_count      <= array_count_next;
      declared_length  <= declared_length_next;
      items_done       <= items_done_next;
      line_length      <= line_length_next;
      decimal_value    <= decimal_value_next;
      decimal_phase    <= decimal_phase_next;
      decimal_negative <= decimal_negative_next;
      held_valid       <= held_valid_next;
      held_byte        <= held_byte_next;
      finished         <= finished_next;
      at_line_start    <= at_line_start_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_kind     <= emit_kind;
      out_value    <= emit_value;
      out_mismatch <= emit_mismatch;
      out_index    <= emit_index;
      out_done     <= emit_done;
    end
  end

  assign result.valid           = out_valid;
  assign result.kind            = out_kind;
  assign result.value           = out_value;
  assign result.length_mismatch = out_mismatch;
  assign result.item_index      = out_index;
  assign result.all_items_done  = out_done;

  // checks
  `RAP_ASSERT_NOW(a_no_result_when_finished, emit, !finished,
                  "result produced after all items were done")
  `RAP_ASSERT_NOW(a_end_needs_header, emit && (emit_kind == rap_pkg::KIND_END),
                  count_known && length_known, "item end before count and length known")
  `RAP_ASSERT_NOW(a_flags_only_on_end, emit && (emit_kind != rap_pkg::KIND_END),
                  !emit_mismatch && !emit_done, "end flags set on a non-end result")
  `RAP_ASSERT_NEXT(a_buffer_end_clears, in_fire && stream.end_of_buffer,
                   !held_valid && !count_known && !finished && at_line_start,
                   "parser state not cleared after end of buffer")

endmodule
